@@ sv/gtl_pkg.sv @@
package gtl_pkg;

  localparam int COORD_BITS_DEF = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int SIZE_W     = 6;
  localparam int BYTE_W     = 8;
  localparam int POS_W      = 16;
  localparam int OFF_W      = 22;
  localparam int IDX_W      = 15;
  localparam int GB_W       = 8;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AREA_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AREA_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FONT_SIZE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DRAW_MODE   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLOR  = 3'd6;

  localparam int AREA_WIDTH_RST  = 320;
  localparam int AREA_HEIGHT_RST = 240;
  localparam logic [SIZE_W-1:0] FONT_SIZE_RST = 6'd16;

  localparam logic [BYTE_W-1:0] LEAD_MIN      = 8'h81;
  localparam logic [BYTE_W-1:0] TRAIL_MIN     = 8'h40;
  localparam logic [BYTE_W-1:0] TRAIL_SPLIT   = 8'h7f;
  localparam logic [BYTE_W-1:0] TRAIL_HI_BASE = 8'h41;
  localparam logic [BYTE_W-1:0] BYTE_BAD      = 8'hff;
  localparam logic [BYTE_W-1:0] BYTE_CR       = 8'd13;
  localparam logic [BYTE_W-1:0] BYTE_END      = 8'd0;
  localparam logic [BYTE_W-1:0] ROW_STRIDE    = 8'd190;

  typedef enum logic [1:0] {
    KIND_ASCII = 2'd0,
    KIND_FONT  = 2'd1,
    KIND_BLANK = 2'd2
  } kind_t;

  typedef struct packed {
    logic capture;
    logic halt;
    logic clr_skip;
    logic hold_lead;
    logic hanzi_sel;
    logic wrap;
    logic place;
    logic mul;
    logic load_out;
  } gtl_cmd_t;

  typedef struct packed {
    logic halted;
    logic zero;
    logic skip;
    logic lead;
    logic high;
    logic cr;
    logic stop;
    logic shown;
    logic blank;
  } gtl_status_t;

  // glyph bitmap size in bytes, zero where the font has no glyphs
  function automatic logic [GB_W-1:0] glyph_bytes(input logic [SIZE_W-1:0] size);
    logic [GB_W-1:0] r;
    unique case (size)
      6'd12:   r = 8'd24;
      6'd16:   r = 8'd32;
      6'd24:   r = 8'd72;
      6'd32:   r = 8'd128;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

endpackage

@@ sv/gtl_in_if.sv @@
interface gtl_in_if;
  logic                         valid;
  logic                         ready;
  logic [gtl_pkg::BYTE_W-1:0]   byte_value;
  logic                         first_byte;

  modport source (output valid, output byte_value, output first_byte, input ready);
  modport sink   (input valid, input byte_value, input first_byte, output ready);
endinterface

@@ sv/gtl_out_if.sv @@
interface gtl_out_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   draw_kind;
  logic [gtl_pkg::POS_W-1:0]    pos_x;
  logic [gtl_pkg::POS_W-1:0]    pos_y;
  logic [gtl_pkg::BYTE_W-1:0]   char_code;
  logic [gtl_pkg::OFF_W-1:0]    font_offset;

  modport source (output valid, output draw_kind, output pos_x, output pos_y,
                  output char_code, output font_offset, input ready);
  modport sink   (input valid, input draw_kind, input pos_x, input pos_y,
                  input char_code, input font_offset, output ready);
endinterface

@@ sv/gtl_ctrl.sv @@
module gtl_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  gtl_pkg::gtl_status_t st,
  output gtl_pkg::gtl_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLASS,
    S_STOP,
    S_MUL,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   hanzi_r, hanzi_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    hanzi_nxt     = hanzi_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_CLASS;
        end
      end
      S_CLASS: begin
        state_nxt = S_IDLE;
        priority if (st.halted) begin
        end else if (st.zero) begin
          cmd.halt = 1'b1;
        end else if (st.skip) begin
          cmd.clr_skip = 1'b1;
        end else if (st.lead) begin
          cmd.wrap      = 1'b1;
          cmd.hanzi_sel = 1'b1;
          hanzi_nxt     = 1'b1;
          state_nxt     = S_STOP;
        end else if (st.high) begin
          cmd.hold_lead = 1'b1;
        end else begin
          cmd.wrap  = 1'b1;
          hanzi_nxt = 1'b0;
          state_nxt = S_STOP;
        end
      end
      S_STOP: begin
        cmd.hanzi_sel = hanzi_r;
        state_nxt     = S_IDLE;
        if (st.stop) begin
          cmd.halt = 1'b1;
        end else begin
          cmd.place = 1'b1;
          if (hanzi_r) begin
            if (st.shown) state_nxt = st.blank ? S_EMIT : S_MUL;
          end else if (!st.cr) begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hanzi_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hanzi_r     <= hanzi_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ sv/gtl_dp.sv @@
module gtl_dp #(
  parameter int COORD_BITS = gtl_pkg::COORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [gtl_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [gtl_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [gtl_pkg::BYTE_W-1:0]      in_byte,
  input  logic                            in_first,
  input  gtl_pkg::gtl_cmd_t               cmd,
  output gtl_pkg::gtl_status_t            st,
  output logic [1:0]                      out_kind,
  output logic [gtl_pkg::POS_W-1:0]       out_x,
  output logic [gtl_pkg::POS_W-1:0]       out_y,
  output logic [gtl_pkg::BYTE_W-1:0]      out_code,
  output logic [gtl_pkg::OFF_W-1:0]       out_off
);

  localparam int CB = COORD_BITS;
  localparam int CW = COORD_BITS + 1;

  logic [CB-1:0] ox_r, oy_r, aw_r, ah_r;
  logic [gtl_pkg::SIZE_W-1:0] size_r;

  logic [CB-1:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic [gtl_pkg::BYTE_W-1:0] byte_r, byte_nxt, lead_r, lead_nxt;
  logic lead_pend_r, lead_pend_nxt, skip_r, skip_nxt, halted_r, halted_nxt;

  logic [1:0]                 res_kind_r, res_kind_nxt;
  logic [CB-1:0]              res_x_r, res_x_nxt, res_y_r, res_y_nxt;
  logic [gtl_pkg::BYTE_W-1:0] res_code_r, res_code_nxt;
  logic [gtl_pkg::IDX_W-1:0]  idx_r, idx_nxt;
  logic [gtl_pkg::OFF_W-1:0]  res_off_r, res_off_nxt;

  logic [1:0]                 out_kind_r;
  logic [CB-1:0]              out_x_r, out_y_r;
  logic [gtl_pkg::BYTE_W-1:0] out_code_r;
  logic [gtl_pkg::OFF_W-1:0]  out_off_r;

  logic [gtl_pkg::SIZE_W-1:0] half, adv;
  logic [gtl_pkg::BYTE_W-1:0] row, col;
  logic                       wrap_hit, blank;

  assign half = size_r >> 1;
  assign adv  = cmd.hanzi_sel ? size_r : half;
  assign wrap_hit = ({1'b0, cx_r} + CW'(adv)) > ({1'b0, ox_r} + {1'b0, aw_r});
  assign blank = (lead_r < gtl_pkg::LEAD_MIN) || (byte_r < gtl_pkg::TRAIL_MIN) ||
                 (byte_r == gtl_pkg::BYTE_BAD) || (lead_r == gtl_pkg::BYTE_BAD);
  assign row = lead_r - gtl_pkg::LEAD_MIN;
  assign col = (byte_r < gtl_pkg::TRAIL_SPLIT) ? (byte_r - gtl_pkg::TRAIL_MIN)
                                               : (byte_r - gtl_pkg::TRAIL_HI_BASE);

  always_comb begin
    st.halted = halted_r;
    st.zero   = (byte_r == gtl_pkg::BYTE_END);
    st.skip   = skip_r;
    st.lead   = lead_pend_r;
    st.high   = (byte_r >= gtl_pkg::LEAD_MIN);
    st.cr     = (byte_r == gtl_pkg::BYTE_CR);
    st.stop   = ({1'b0, cy_r} + CW'(size_r)) > ({1'b0, oy_r} + {1'b0, ah_r});
    st.shown  = (gtl_pkg::glyph_bytes(size_r) != '0);
    st.blank  = blank;
  end

  always_comb begin
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    byte_nxt      = byte_r;
    lead_nxt      = lead_r;
    lead_pend_nxt = lead_pend_r;
    skip_nxt      = skip_r;
    halted_nxt    = halted_r;
    res_kind_nxt  = res_kind_r;
    res_x_nxt     = res_x_r;
    res_y_nxt     = res_y_r;
    res_code_nxt  = res_code_r;
    idx_nxt       = idx_r;
    res_off_nxt   = res_off_r;

    if (cmd.capture) begin
      byte_nxt = in_byte;
      if (in_first) begin
        cx_nxt        = ox_r;
        cy_nxt        = oy_r;
        lead_pend_nxt = 1'b0;
        skip_nxt      = 1'b0;
        halted_nxt    = 1'b0;
      end
    end
    if (cmd.halt) begin
      halted_nxt    = 1'b1;
      lead_pend_nxt = 1'b0;
      skip_nxt      = 1'b0;
    end
    if (cmd.clr_skip) skip_nxt = 1'b0;
    if (cmd.hold_lead) begin
      lead_nxt      = byte_r;
      lead_pend_nxt = 1'b1;
    end
    if (cmd.wrap) begin
      if (cmd.hanzi_sel) lead_pend_nxt = 1'b0;
      if (wrap_hit) begin
        cy_nxt = cy_r + CB'(size_r);
        cx_nxt = ox_r;
      end
    end
    if (cmd.place) begin
      res_x_nxt   = cx_r;
      res_y_nxt   = cy_r;
      res_off_nxt = '0;
      if (cmd.hanzi_sel) begin
        res_kind_nxt = blank ? gtl_pkg::KIND_BLANK : gtl_pkg::KIND_FONT;
        res_code_nxt = '0;
        idx_nxt      = gtl_pkg::IDX_W'(row) * gtl_pkg::IDX_W'(gtl_pkg::ROW_STRIDE) +
                       gtl_pkg::IDX_W'(col);
        cx_nxt       = cx_r + CB'(size_r);
      end else if (byte_r == gtl_pkg::BYTE_CR) begin
        cy_nxt   = cy_r + CB'(size_r);
        cx_nxt   = ox_r + CB'(half);
        skip_nxt = 1'b1;
      end else begin
        res_kind_nxt = gtl_pkg::KIND_ASCII;
        res_code_nxt = byte_r;
        cx_nxt       = cx_r + CB'(half);
      end
    end
    if (cmd.mul) begin
      res_off_nxt = gtl_pkg::OFF_W'(idx_r) *
                    gtl_pkg::OFF_W'(gtl_pkg::glyph_bytes(size_r));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ox_r        <= '0;
      oy_r        <= '0;
      aw_r        <= CB'(gtl_pkg::AREA_WIDTH_RST);
      ah_r        <= CB'(gtl_pkg::AREA_HEIGHT_RST);
      size_r      <= gtl_pkg::FONT_SIZE_RST;
      cx_r        <= '0;
      cy_r        <= '0;
      lead_r      <= '0;
      lead_pend_r <= 1'b0;
      skip_r      <= 1'b0;
      halted_r    <= 1'b1;
    end else begin
      if (cfg_we) begin
        // draw mode and colour belong to the pixel drawer
        unique case (cfg_idx)
          gtl_pkg::REG_ORIGIN_X:    ox_r   <= cfg_data[CB-1:0];
          gtl_pkg::REG_ORIGIN_Y:    oy_r   <= cfg_data[CB-1:0];
          gtl_pkg::REG_AREA_WIDTH:  aw_r   <= cfg_data[CB-1:0];
          gtl_pkg::REG_AREA_HEIGHT: ah_r   <= cfg_data[CB-1:0];
          gtl_pkg::REG_FONT_SIZE:   size_r <= cfg_data[gtl_pkg::SIZE_W-1:0];
          default: ;
        endcase
      end
      cx_r        <= cx_nxt;
      cy_r        <= cy_nxt;
      lead_r      <= lead_nxt;
      lead_pend_r <= lead_pend_nxt;
      skip_r      <= skip_nxt;
      halted_r    <= halted_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r     <= byte_nxt;
    res_kind_r <= res_kind_nxt;
    res_x_r    <= res_x_nxt;
    res_y_r    <= res_y_nxt;
    res_code_r <= res_code_nxt;
    idx_r      <= idx_nxt;
    res_off_r  <= res_off_nxt;
    if (cmd.load_out) begin
      out_kind_r <= res_kind_r;
      out_x_r    <= res_x_r;
      out_y_r    <= res_y_r;
      out_code_r <= res_code_r;
      out_off_r  <= res_off_r;
    end
  end

  assign out_kind = out_kind_r;
  assign out_x    = gtl_pkg::POS_W'(out_x_r);
  assign out_y    = gtl_pkg::POS_W'(out_y_r);
  assign out_code = out_code_r;
  assign out_off  = out_off_r;

endmodule

@@ sv/gbk_text_layout_engine.sv @@
// channel  dir  handshake           word
// in_ch    in   valid/ready         byte_value[7:0], first_byte
// out_ch   out  valid/ready         draw_kind[1:0], pos_x, pos_y, char_code, font_offset
// cfg_*    in   cfg_we, no stall    cfg_idx[2:0], cfg_data[15:0]
//
// The sequencer captures and decodes a byte; a lead byte, a dropped byte, a
// byte of a halted string or the end of string ends there. A carriage return,
// a hanzi that is not drawn or a glyph past the area bottom ends after the
// wrap/stop test; an ascii or blank glyph then gets output load, a font glyph offset multiply and load.
// The output register frees the input side: a new byte is taken while a word
// waits; a glyph stalls only in its load cycle while the previous word is held.
// rst_n is synchronous; no memory to clear.
module gbk_text_layout_engine #(
  parameter int COORD_BITS = gtl_pkg::COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  gtl_in_if.sink                         in_ch,
  gtl_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [gtl_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [gtl_pkg::CFG_DATA_W-1:0] cfg_data
);

  gtl_pkg::gtl_cmd_t    cmd;
  gtl_pkg::gtl_status_t st;
  logic                 in_ready;
  logic                 out_valid;

  gtl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .st        (st),
    .cmd       (cmd)
  );

  gtl_dp #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_byte  (in_ch.byte_value),
    .in_first (in_ch.first_byte),
    .cmd      (cmd),
    .st       (st),
    .out_kind (out_ch.draw_kind),
    .out_x    (out_ch.pos_x),
    .out_y    (out_ch.pos_y),
    .out_code (out_ch.char_code),
    .out_off  (out_ch.font_offset)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid || out_ch.ready))
    else $error("output register overwritten while held");

  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ready) |=> !in_ready)
    else $error("second word taken while one is in progress");

  a_halt: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.halt |=> (st.halted && !st.lead && !st.skip))
    else $error("halt left string state behind");

  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_ch.draw_kind == gtl_pkg::KIND_ASCII ||
                   out_ch.draw_kind == gtl_pkg::KIND_FONT ||
                   out_ch.draw_kind == gtl_pkg::KIND_BLANK))
    else $error("undefined draw kind");

endmodule
